// File: rtl/adjsc_pkg.sv
// ----------------------------------------------------------------------------
// adjsc_pkg
// Shared types and constants for the adjoint stencil scatter block.
// ----------------------------------------------------------------------------
package adjsc_pkg;

	// Input item modes
	localparam logic [1:0] MODE_LOAD_LEFT  = 2'd0;
	localparam logic [1:0] MODE_LOAD_RIGHT = 2'd1;
	localparam logic [1:0] MODE_SAMPLE     = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_FRAME_LENGTH  = 2'd0;
	localparam logic [1:0] CFG_HALF_WIDTH    = 2'd1;
	localparam logic [1:0] CFG_CENTER_WEIGHT = 2'd2;

	// Reset values of the configuration registers
	localparam logic [15:0] FRAME_LENGTH_RST = 16'd1024;
	localparam logic [3:0]  HALF_WIDTH_RST   = 4'd1;

	// Command queue depth between front and back (power of two)
	localparam int QUEUE_DEPTH = 4;

	// Input transaction
	typedef struct packed {
		logic [1:0]         mode;
		logic [2:0]         tap_index;
		logic signed [15:0] weight;
		logic signed [15:0] sample;
	} in_item_t;

	// Output transaction
	typedef struct packed {
		logic signed [39:0] adjoint_value;
		logic [15:0]        position;
		logic               frame_end;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_LOAD_LEFT,
		CMD_LOAD_RIGHT,
		CMD_SAMPLE
	} cmd_kind_t;

	// Classified command handed from front to back
	typedef struct packed {
		cmd_kind_t          kind;
		logic [2:0]         tap;
		logic signed [15:0] weight;
		logic signed [15:0] sample;
		logic               scatter; // sample adds products
		logic               last;    // final sample of the frame: flush
		logic               emit;    // one result for a non-final sample at i >= radius
		logic [3:0]         hs;      // radius of the frame
		logic [15:0]        pos;     // emit position, or first flush position
		logic [3:0]         span;    // flush covers span+1 positions
	} cmd_t;

	// Front status, watched by the top level
	typedef struct packed {
		logic [15:0] count;
		logic [15:0] frame_n;
	} front_status_t;

endpackage

// File: rtl/adjsc_front.sv
// ----------------------------------------------------------------------------
// adjsc_front
// Accepts input transactions, tracks the position in the frame, latches the
// frame geometry and classifies each item into a command for the back end.
// ----------------------------------------------------------------------------
module adjsc_front #(
	parameter int MAX_HALF_WIDTH = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  adjsc_pkg::in_item_t       in_data,
	input  logic [15:0]               frame_length,
	input  logic [3:0]                half_width,
	input  logic                      q_full,
	output logic                      q_push,
	output adjsc_pkg::cmd_t           q_cmd,
	output adjsc_pkg::front_status_t  status
);

	logic [15:0] count_q;
	logic [15:0] frame_n_q;
	logic [3:0]  frame_s_q;

	logic        first;
	logic [15:0] n_live;
	logic [3:0]  s_live;
	logic [15:0] n_cur;
	logic [3:0]  s_cur;
	logic [16:0] i_ext;
	logic [16:0] n_ext;
	logic        take;
	logic        is_sample;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;

	// Geometry in force: live config at a frame's first sample, else latched
	always_comb begin
		n_live = (frame_length == 16'd0) ? 16'd1 : frame_length;
		s_live = ({12'd0, half_width} > 16'(MAX_HALF_WIDTH)) ? 4'(MAX_HALF_WIDTH)
			: half_width;
		first  = (count_q == 16'd0);
		n_cur  = first ? n_live : frame_n_q;
		s_cur  = first ? s_live : frame_s_q;
		i_ext  = {1'b0, count_q};
		n_ext  = {1'b0, n_cur};
	end

	// Classification
	always_comb begin
		q_cmd         = '0;
		q_cmd.tap     = in_data.tap_index;
		q_cmd.weight  = in_data.weight;
		q_cmd.sample  = in_data.sample;
		q_cmd.hs      = s_cur;
		q_cmd.scatter = (count_q >= {12'd0, s_cur}) && ((i_ext + {13'd0, s_cur}) < n_ext);
		q_cmd.last    = ((i_ext + 17'd1) >= n_ext);
		q_cmd.emit    = !q_cmd.last && (count_q >= {12'd0, s_cur});
		q_cmd.span    = (count_q < {12'd0, s_cur}) ? count_q[3:0] : s_cur;
		q_cmd.pos     = q_cmd.last ? (count_q - {12'd0, q_cmd.span})
			: (count_q - {12'd0, s_cur});
		is_sample     = 1'b0;
		q_push        = 1'b0;
		unique case (in_data.mode)
			adjsc_pkg::MODE_LOAD_LEFT: begin
				q_cmd.kind = adjsc_pkg::CMD_LOAD_LEFT;
				q_push     = take;
			end
			adjsc_pkg::MODE_LOAD_RIGHT: begin
				q_cmd.kind = adjsc_pkg::CMD_LOAD_RIGHT;
				q_push     = take;
			end
			adjsc_pkg::MODE_SAMPLE: begin
				q_cmd.kind = adjsc_pkg::CMD_SAMPLE;
				q_push     = take;
				is_sample  = 1'b1;
			end
			default: begin
				// unused mode: dropped
				q_cmd.kind = adjsc_pkg::CMD_SAMPLE;
			end
		endcase
	end

	// Position counter and frame latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			frame_n_q <= adjsc_pkg::FRAME_LENGTH_RST;
			frame_s_q <= adjsc_pkg::HALF_WIDTH_RST;
		end else if (take && is_sample) begin
			frame_n_q <= n_cur;
			frame_s_q <= s_cur;
			count_q   <= q_cmd.last ? 16'd0 : count_q + 16'd1;
		end
	end

	assign status.count   = count_q;
	assign status.frame_n = frame_n_q;

endmodule

// File: rtl/adjsc_fifo.sv
// ----------------------------------------------------------------------------
// adjsc_fifo
// Short command queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
module adjsc_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  adjsc_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output adjsc_pkg::cmd_t pop_cmd,
	output logic            not_empty
);

	localparam int PW = $clog2(adjsc_pkg::QUEUE_DEPTH);

	adjsc_pkg::cmd_t entries_q [adjsc_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;

	assign full      = (count_q == (PW+1)'(adjsc_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_cmd   = entries_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/adjsc_back.sv
// ----------------------------------------------------------------------------
// adjsc_back
// Executes commands: tap loads, one product per lane (stage 1), accumulation
// into a shifting window of sums with result emission and frame flush
// (stage 2), and the output register.
// ----------------------------------------------------------------------------
module adjsc_back #(
	parameter int MAX_HALF_WIDTH = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  adjsc_pkg::cmd_t      q_cmd,
	output logic                 q_pop,
	input  logic signed [15:0]   center_weight,
	output logic                 out_valid,
	input  logic                 out_ready,
	output adjsc_pkg::out_item_t out_data
);

	localparam int LANES = 2 * MAX_HALF_WIDTH + 1;
	localparam int LW    = $clog2(LANES);

	// Lane d of the window holds the sum for position i - MAX_HALF_WIDTH + d
	logic signed [15:0] left_taps_q  [MAX_HALF_WIDTH];
	logic signed [15:0] right_taps_q [MAX_HALF_WIDTH];

	logic signed [15:0] lane_w    [LANES];
	logic signed [31:0] lane_prod [LANES];
	logic signed [15:0] smp;

	logic               valid_s1;
	adjsc_pkg::cmd_t    cmd_s1;
	logic signed [31:0] prod_s1 [LANES];

	logic signed [39:0] acc_q   [LANES];
	logic signed [39:0] new_acc [LANES];
	logic               flushing_q;
	logic [LW-1:0]      flush_lane_q;
	logic [15:0]        flush_pos_q;

	logic                 out_valid_q;
	adjsc_pkg::out_item_t out_q;

	logic                 out_free;
	logic                 s2_take;
	logic                 s1_free;
	logic                 is_sample;
	logic                 emit_now;
	logic                 flush_done;
	logic [LW-1:0]        emit_lane;
	adjsc_pkg::out_item_t emit_item;

	assign is_sample  = (q_cmd.kind == adjsc_pkg::CMD_SAMPLE);
	assign out_free   = !out_valid_q || out_ready;
	assign s2_take    = valid_s1 && !flushing_q && (!cmd_s1.emit || out_free);
	assign s1_free    = !valid_s1 || s2_take;
	assign q_pop      = q_valid && (!is_sample || s1_free);
	assign flush_done = (flush_lane_q == LW'(MAX_HALF_WIDTH));
	assign emit_lane  = LW'(MAX_HALF_WIDTH) - LW'(cmd_s1.hs);

	// Lane weights and products
	assign smp = q_cmd.scatter ? q_cmd.sample : '0;

	for (genvar d = 0; d < LANES; d++) begin : g_lane
		if (d < MAX_HALF_WIDTH) begin : g_left
			assign lane_w[d] = (int'(q_cmd.hs) > (MAX_HALF_WIDTH - 1 - d))
				? left_taps_q[MAX_HALF_WIDTH - 1 - d] : '0;
		end else if (d == MAX_HALF_WIDTH) begin : g_center
			assign lane_w[d] = center_weight;
		end else begin : g_right
			assign lane_w[d] = (int'(q_cmd.hs) > (d - MAX_HALF_WIDTH - 1))
				? right_taps_q[d - MAX_HALF_WIDTH - 1] : '0;
		end
		assign lane_prod[d] = lane_w[d] * smp;
		assign new_acc[d]   = acc_q[d] + 40'(prod_s1[d]);
	end

	// Tap tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_HALF_WIDTH; k++) begin
				left_taps_q[k]  <= '0;
				right_taps_q[k] <= '0;
			end
		end else if (q_pop) begin
			for (int k = 0; k < MAX_HALF_WIDTH; k++) begin
				if (int'(q_cmd.tap) == k) begin
					if (q_cmd.kind == adjsc_pkg::CMD_LOAD_LEFT) begin
						left_taps_q[k] <= q_cmd.weight;
					end
					if (q_cmd.kind == adjsc_pkg::CMD_LOAD_RIGHT) begin
						right_taps_q[k] <= q_cmd.weight;
					end
				end
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= q_pop && is_sample;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (s1_free && q_pop && is_sample) begin
			cmd_s1 <= q_cmd;
			for (int d = 0; d < LANES; d++) begin
				prod_s1[d] <= lane_prod[d];
			end
		end
	end

	// Result selection: flush walks the window, otherwise one lane per sample
	always_comb begin
		emit_item = '0;
		if (flushing_q) begin
			emit_item.adjoint_value = acc_q[flush_lane_q];
			emit_item.position      = flush_pos_q;
			emit_item.frame_end     = flush_done;
		end else begin
			emit_item.adjoint_value = new_acc[emit_lane];
			emit_item.position      = cmd_s1.pos;
			emit_item.frame_end     = 1'b0;
		end
		emit_now = (flushing_q && out_free) || (s2_take && cmd_s1.emit);
	end

	// Stage 2: window of sums and flush sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < LANES; d++) begin
				acc_q[d] <= '0;
			end
			flushing_q   <= 1'b0;
			flush_lane_q <= '0;
			flush_pos_q  <= '0;
		end else if (flushing_q) begin
			if (out_free) begin
				if (flush_done) begin
					flushing_q <= 1'b0;
					for (int d = 0; d < LANES; d++) begin
						acc_q[d] <= '0;
					end
				end else begin
					flush_lane_q <= flush_lane_q + 1'b1;
					flush_pos_q  <= flush_pos_q + 16'd1;
				end
			end
		end else if (s2_take) begin
			if (cmd_s1.last) begin
				for (int d = 0; d < LANES; d++) begin
					acc_q[d] <= new_acc[d];
				end
				flushing_q   <= 1'b1;
				flush_lane_q <= LW'(MAX_HALF_WIDTH) - LW'(cmd_s1.span);
				flush_pos_q  <= cmd_s1.pos;
			end else begin
				// advance the window by one position
				for (int d = 0; d < LANES - 1; d++) begin
					acc_q[d] <= new_acc[d + 1];
				end
				acc_q[LANES - 1] <= '0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_now) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_now) begin
			out_q <= emit_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: rtl/adjoint_stencil_scatter.sv
// ----------------------------------------------------------------------------
// adjoint_stencil_scatter
// Path: a non-final sample's result passes the command queue, stage 1 and the
// output register; a last sample's flush starts once stage 2 takes it.
// Throughput: one item per cycle while the queue has room; the last sample holds
// stage 2 while its min(i, S) + 1 results leave, one per cycle if not stalled.
// Reset clears taps and sums and loads frame_length 1024, half_width 1,
// center_weight 0.
// ----------------------------------------------------------------------------
module adjoint_stencil_scatter #(
	parameter int MAX_HALF_WIDTH = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  adjsc_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output adjsc_pkg::out_item_t out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data
);

	logic [15:0]        frame_length_q;
	logic [3:0]         half_width_q;
	logic signed [15:0] center_weight_q;

	logic                     q_full;
	logic                     q_push;
	adjsc_pkg::cmd_t          push_cmd;
	logic                     q_pop;
	adjsc_pkg::cmd_t          pop_cmd;
	logic                     q_valid;
	adjsc_pkg::front_status_t front_status;
	logic [15:0]              expect_pos_q;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q  <= adjsc_pkg::FRAME_LENGTH_RST;
			half_width_q    <= adjsc_pkg::HALF_WIDTH_RST;
			center_weight_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				adjsc_pkg::CFG_FRAME_LENGTH:  frame_length_q  <= cfg_data;
				adjsc_pkg::CFG_HALF_WIDTH:    half_width_q    <= cfg_data[3:0];
				adjsc_pkg::CFG_CENTER_WEIGHT: center_weight_q <= cfg_data;
				default: ;
			endcase
		end
	end

	adjsc_front #(
		.MAX_HALF_WIDTH(MAX_HALF_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.frame_length (frame_length_q),
		.half_width   (half_width_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_cmd        (push_cmd),
		.status       (front_status)
	);

	adjsc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.pop_cmd   (pop_cmd),
		.not_empty (q_valid)
	);

	adjsc_back #(
		.MAX_HALF_WIDTH(MAX_HALF_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_cmd         (pop_cmd),
		.q_pop         (q_pop),
		.center_weight (center_weight_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data)
	);

	// Expected next result position: every frame delivers 0 .. N-1 in order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_pos_q <= '0;
		end else if (out_valid && out_ready) begin
			expect_pos_q <= out_data.frame_end ? 16'd0 : out_data.position + 16'd1;
		end
	end

	// Position counter stays inside the latched frame
	a_count_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		front_status.count < front_status.frame_n)
		else $error("sample counter left the frame");

	// Results come out in position order with no gap or repeat
	a_position_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |-> (out_data.position == expect_pos_q))
		else $error("result position out of sequence");

	// A frame end restarts the expected position sequence at zero
	a_end_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_data.frame_end)
			|=> (expect_pos_q == 16'd0))
		else $error("frame end did not restart the position sequence");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for adjoint_stencil_scatter. Tap loads, samples and
// register writes go in over valid/ready; an in-bench model of the transposed
// stencil predicts every emitted sum, and each output transaction is compared
// field by field against the oldest prediction. Both sides idle at random,
// and the receiver also holds off for a long stretch to back up the pipeline.
// ----------------------------------------------------------------------------
module tb;

	localparam int          MAX_HW         = 8;
	localparam int          RING           = 2 * MAX_HW + 1;
	localparam logic [1:0]  MODE_UNUSED    = 2'd3;
	localparam logic [1:0]  CFG_UNUSED     = 2'd3;
	localparam int          DRAIN_CYCLES   = 12;
	localparam int          LONG_HOLD      = 300;
	localparam int          WATCHDOG_LIMIT = 3000;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	adjsc_pkg::in_item_t  in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	adjsc_pkg::out_item_t out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	adjoint_stencil_scatter #(
		.MAX_HALF_WIDTH(MAX_HW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Idle rates, hold-off request and run statistics
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	logic        hold_toggle    = 1'b0;
	logic        hold_seen      = 1'b0;
	int unsigned hold_left      = 0;
	int unsigned fail_count     = 0;
	int unsigned items_sent     = 0;
	int unsigned results_checked = 0;
	int unsigned frames_closed  = 0;
	int unsigned cfg_writes     = 0;
	int unsigned stall_cycles   = 0;

	// Stencil model state
	logic signed [15:0] left_w [MAX_HW];
	logic signed [15:0] right_w [MAX_HW];
	logic signed [39:0] sums [RING];
	int unsigned        sample_idx;
	int unsigned        frame_n;
	int unsigned        frame_s;
	logic [15:0]        reg_frame_len;
	logic [3:0]         reg_half;
	logic signed [15:0] reg_center;

	adjsc_pkg::out_item_t adj_expect_q[$];

	function automatic void add_product(input int unsigned pos, input logic signed [15:0] w,
			input logic signed [15:0] s);
		sums[pos % RING] = sums[pos % RING] + w * s;
	endfunction

	function automatic void expect_position(input int unsigned pos, input logic last);
		adjsc_pkg::out_item_t res;
		res.adjoint_value = sums[pos % RING];
		res.position      = 16'(pos);
		res.frame_end     = last;
		adj_expect_q.push_back(res);
		sums[pos % RING] = '0;
	endfunction

	// Apply one accepted transaction to the model and queue its sums
	function automatic void predict_item(input adjsc_pkg::in_item_t item);
		int unsigned idx;
		int unsigned first;
		int unsigned k;
		case (item.mode)
			adjsc_pkg::MODE_LOAD_LEFT: begin
				left_w[item.tap_index] = item.weight;
			end
			adjsc_pkg::MODE_LOAD_RIGHT: begin
				right_w[item.tap_index] = item.weight;
			end
			adjsc_pkg::MODE_SAMPLE: begin
				// frame geometry is latched at the first sample
				if (sample_idx == 0) begin
					frame_n = (reg_frame_len == 0) ? 1 : reg_frame_len;
					frame_s = (reg_half > MAX_HW) ? MAX_HW : reg_half;
					foreach (sums[r])
						sums[r] = '0;
				end
				idx = sample_idx;
				if (idx >= frame_s && idx + frame_s < frame_n) begin
					for (k = 0; k < frame_s; k++) begin
						add_product(idx - k - 1, left_w[k], item.sample);
						add_product(idx + k + 1, right_w[k], item.sample);
					end
					add_product(idx, reg_center, item.sample);
				end
				if (idx + 1 >= frame_n) begin
					// last sample flushes everything still open
					first = (idx >= frame_s) ? idx - frame_s : 0;
					for (k = first; k < frame_n; k++)
						expect_position(k, k + 1 == frame_n);
					sample_idx = 0;
					frames_closed++;
				end else begin
					if (idx >= frame_s)
						expect_position(idx - frame_s, 1'b0);
					sample_idx = idx + 1;
				end
			end
			default: begin
				// unused mode: no effect
			end
		endcase
	endfunction

	// Item builders; unused fields carry random bits
	function automatic adjsc_pkg::in_item_t make_sample(input logic [15:0] s);
		adjsc_pkg::in_item_t item;
		item.mode      = adjsc_pkg::MODE_SAMPLE;
		item.tap_index = 3'($urandom);
		item.weight    = 16'($urandom);
		item.sample    = s;
		return item;
	endfunction

	function automatic adjsc_pkg::in_item_t make_load(input logic [1:0] mode,
			input logic [2:0] tap, input logic [15:0] w);
		adjsc_pkg::in_item_t item;
		item.mode      = mode;
		item.tap_index = tap;
		item.weight    = w;
		item.sample    = 16'($urandom);
		return item;
	endfunction

	function automatic logic [15:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Send one input transaction; each cycle slot before it idles at the set rate
	task automatic send_item(input adjsc_pkg::in_item_t item);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_item(item);
		if (item.mode != MODE_UNUSED)
			items_sent++;
	endtask

	// Stop sending and wait until every predicted sum has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (adj_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (index)
			adjsc_pkg::CFG_FRAME_LENGTH:  reg_frame_len = value;
			adjsc_pkg::CFG_HALF_WIDTH:    reg_half      = value[3:0];
			adjsc_pkg::CFG_CENTER_WEIGHT: reg_center    = value;
			default: ;
		endcase
		cfg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Extreme taps and samples, tap 7 loads, unused mode and register index
	task automatic test_directed_extremes();
		logic [15:0] samples [10];
		samples = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h0000,
			16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h7fff};
		write_reg(adjsc_pkg::CFG_FRAME_LENGTH, 16'd10);
		write_reg(adjsc_pkg::CFG_HALF_WIDTH, 16'd2);
		write_reg(adjsc_pkg::CFG_CENTER_WEIGHT, 16'h7fff);
		write_reg(CFG_UNUSED, 16'hffff);
		send_item(make_load(adjsc_pkg::MODE_LOAD_LEFT, 3'd0, 16'h8000));
		send_item(make_load(adjsc_pkg::MODE_LOAD_LEFT, 3'd1, 16'h7fff));
		send_item(make_load(adjsc_pkg::MODE_LOAD_RIGHT, 3'd0, 16'h7fff));
		send_item(make_load(adjsc_pkg::MODE_LOAD_RIGHT, 3'd1, 16'h8000));
		send_item(make_load(adjsc_pkg::MODE_LOAD_LEFT, 3'd7, 16'h5a5a));
		send_item(make_load(adjsc_pkg::MODE_LOAD_RIGHT, 3'd7, 16'ha5a5));
		send_item(make_load(MODE_UNUSED, 3'd5, 16'h1234));
		foreach (samples[k])
			send_item(make_sample(samples[k]));
	endtask

	// Zero frame length acts as one; frame no longer than twice the radius
	task automatic test_short_frames();
		wait_drained();
		write_reg(adjsc_pkg::CFG_FRAME_LENGTH, 16'd0);
		write_reg(adjsc_pkg::CFG_CENTER_WEIGHT, 16'h8000);
		send_item(make_sample(16'h7fff));
		send_item(make_sample(16'h8000));
		wait_drained();
		write_reg(adjsc_pkg::CFG_FRAME_LENGTH, 16'd4);
		repeat (4) send_item(make_sample(rand_word()));
	endtask

	// Length and radius changes wait for the next frame; centre and taps do not
	task automatic test_config_mid_frame();
		wait_drained();
		write_reg(adjsc_pkg::CFG_FRAME_LENGTH, 16'd8);
		write_reg(adjsc_pkg::CFG_HALF_WIDTH, 16'd1);
		repeat (3) send_item(make_sample(rand_word()));
		wait_drained();
		write_reg(adjsc_pkg::CFG_FRAME_LENGTH, 16'd5);
		write_reg(adjsc_pkg::CFG_HALF_WIDTH, 16'd3);
		write_reg(adjsc_pkg::CFG_CENTER_WEIGHT, rand_word());
		send_item(make_load(adjsc_pkg::MODE_LOAD_LEFT, 3'd0, rand_word()));
		repeat (5) send_item(make_sample(rand_word()));
		repeat (5) send_item(make_sample(rand_word()));
	endtask

	// Whole frames of random geometry with loads and noise mixed in
	task automatic test_random_frames(input int unsigned n_items);
		int unsigned sent;
		int unsigned len;
		int unsigned eff_len;
		int unsigned pick;
		int unsigned k;
		sent = 0;
		while (sent < n_items) begin
			wait_drained();
			pick = $urandom_range(0, 99);
			if (pick < 8)
				len = 0;
			else if (pick < 20)
				len = $urandom_range(1, 3);
			else
				len = $urandom_range(4, 24);
			write_reg(adjsc_pkg::CFG_FRAME_LENGTH, 16'(len));
			write_reg(adjsc_pkg::CFG_HALF_WIDTH, {12'($urandom), 4'($urandom_range(0, 15))});
			if ($urandom_range(0, 1))
				write_reg(adjsc_pkg::CFG_CENTER_WEIGHT, rand_word());
			eff_len = (len == 0) ? 1 : len;
			for (k = 0; k < eff_len; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 12) begin
					send_item(make_load($urandom_range(0, 1) ? adjsc_pkg::MODE_LOAD_RIGHT
						: adjsc_pkg::MODE_LOAD_LEFT, 3'($urandom), rand_word()));
					sent++;
				end else if (pick < 16) begin
					send_item(make_load(MODE_UNUSED, 3'($urandom), 16'($urandom)));
				end
				send_item(make_sample(rand_word()));
				sent++;
			end
		end
	endtask

	// Receiver holds off while a wide-radius frame streams in
	task automatic test_backpressure();
		int unsigned k;
		wait_drained();
		write_reg(adjsc_pkg::CFG_FRAME_LENGTH, 16'd24);
		write_reg(adjsc_pkg::CFG_HALF_WIDTH, 16'd8);
		for (k = 0; k < MAX_HW; k++) begin
			send_item(make_load(adjsc_pkg::MODE_LOAD_LEFT, 3'(k), rand_word()));
			send_item(make_load(adjsc_pkg::MODE_LOAD_RIGHT, 3'(k), rand_word()));
		end
		hold_toggle <= ~hold_toggle;
		repeat (24) send_item(make_sample(rand_word()));
	endtask

	// Longest frame, radius beyond the maximum; the frame stays open
	task automatic test_long_frame();
		wait_drained();
		write_reg(adjsc_pkg::CFG_FRAME_LENGTH, 16'hffff);
		write_reg(adjsc_pkg::CFG_HALF_WIDTH, 16'd15);
		repeat (16) send_item(make_sample(rand_word()));
	endtask

	// Receiver with random stalls and result checking
	always @(posedge clk) begin : result_monitor
		adjsc_pkg::out_item_t want;
		if (out_valid && out_ready) begin
			results_checked++;
			if (adj_expect_q.size() == 0) begin
				$error("unexpected result: position %0d value %0d",
					out_data.position, out_data.adjoint_value);
				fail_count++;
			end else begin
				want = adj_expect_q.pop_front();
				if (out_data.adjoint_value !== want.adjoint_value) begin
					$error("adjoint_value: expected %0d, got %0d",
						want.adjoint_value, out_data.adjoint_value);
					fail_count++;
				end
				if (out_data.position !== want.position) begin
					$error("position: expected %0d, got %0d",
						want.position, out_data.position);
					fail_count++;
				end
				if (out_data.frame_end !== want.frame_end) begin
					$error("frame_end: expected %0b, got %0b",
						want.frame_end, out_data.frame_end);
					fail_count++;
				end
			end
		end
		if (hold_toggle != hold_seen) begin
			hold_seen = hold_toggle;
			hold_left = LONG_HOLD;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Watchdog: too long without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("adjoint_stencil_scatter verification failed");
			$finish;
		end
	end

	initial begin
		foreach (left_w[k]) begin
			left_w[k]  = '0;
			right_w[k] = '0;
		end
		foreach (sums[k])
			sums[k] = '0;
		sample_idx    = 0;
		reg_frame_len = adjsc_pkg::FRAME_LENGTH_RST;
		reg_half      = adjsc_pkg::HALF_WIDTH_RST;
		reg_center    = '0;
		frame_n       = reg_frame_len;
		frame_s       = reg_half;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct  = 10;
		recv_stall_pct = 65;
		test_directed_extremes();
		test_short_frames();
		test_config_mid_frame();
		test_random_frames(8);

		send_idle_pct  = 65;
		recv_stall_pct = 10;
		test_random_frames(8);

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_random_frames(8);
		test_backpressure();
		test_long_frame();
		wait_drained();

		$display("covered %0d load/sample transactions and %0d register writes",
			items_sent, cfg_writes);
		$display("checked %0d results across %0d closed frames, %0d mismatches",
			results_checked, frames_closed, fail_count);
		if (fail_count == 0)
			$display("adjoint_stencil_scatter verification clean");
		else
			$display("adjoint_stencil_scatter verification failed");
		$finish;
	end

endmodule
